### hdl/ric_pkg.sv
// ric_pkg: shared types, constants and the control store of the inode cache.
// Used by ric_sequencer, ric_datapath and refcounted_inode_cache.
// No dependencies.
package ric_pkg;

  // Table geometry
  localparam int SLOTS            = 64;
  localparam int INODES_PER_BLOCK = 8;   // power of two
  localparam int SLOT_W           = $clog2(SLOTS);

  // Field widths
  localparam int DEV_W  = 16;
  localparam int INO_W  = 32;
  localparam int IDX_W  = 6;
  localparam int BLK_W  = 32;
  localparam int OFF_W  = 3;
  localparam int CNT_W  = 16;
  localparam int STAT_W = 3;

  // Commands
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ALLOC     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_HELD      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_CLEAN     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_WRITEBACK = 3'd5;
  localparam logic [STAT_W-1:0] STAT_BAD       = 3'd6;

  // Microprogram step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MATCH  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_PICK   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOCATE = 3'd3;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd5;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MATCH,
    OP_PICK,
    OP_LOCATE,
    OP_CHECK,
    OP_COMMIT
  } dp_op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_IN_ACC,
    CND_PUT,
    CND_OUT_FREE
  } cond_e;

  // One control word
  typedef struct packed {
    dp_op_e              op;
    cond_e               cond;
    logic                hold;    // stay on this step when the jump is not taken
    logic [STEP_W-1:0]   target;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic is_put;
    logic out_free;
  } dp_stat_t;

  // Control store: next = jump ? target : (hold ? step : step + 1)
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, hold: 1'b0, target: STEP_LOAD};
    unique case (step)
      STEP_LOAD:   w = '{op: OP_LOAD,   cond: CND_IN_ACC,   hold: 1'b1, target: STEP_MATCH};
      STEP_MATCH:  w = '{op: OP_MATCH,  cond: CND_PUT,      hold: 1'b0, target: STEP_CHECK};
      STEP_PICK:   w = '{op: OP_PICK,   cond: CND_NEVER,    hold: 1'b0, target: STEP_LOAD};
      STEP_LOCATE: w = '{op: OP_LOCATE, cond: CND_ALWAYS,   hold: 1'b0, target: STEP_COMMIT};
      STEP_CHECK:  w = '{op: OP_CHECK,  cond: CND_ALWAYS,   hold: 1'b0, target: STEP_LOCATE};
      STEP_COMMIT: w = '{op: OP_COMMIT, cond: CND_OUT_FREE, hold: 1'b1, target: STEP_LOAD};
      default:     w = '{op: OP_NOP,    cond: CND_ALWAYS,   hold: 1'b0, target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

### hdl/refcounted_inode_cache.sv
// refcounted_inode_cache: top level of the in-core inode slot cache.
// Instantiates ric_sequencer and ric_datapath; depends on ric_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one word per request, a get
//    (command 0: device, inode_number) or a put (command 1: slot, modified).
//    A word is taken when in_valid_i is high and in_stall_o is low.
//  - Output channel (out_valid_o / out_stall_i): one result word per request
//    (status, slot_index, disk_block, block_offset, references).
//  - Config channel (cfg_valid_i / cfg_ready_o): writes the first disk block
//    of the inode table; ready is always high. Write it only while idle.
//  - Timing: a six-step microprogram runs one step per cycle, holding at
//    load for a request and at commit for a free output register; each
//    request runs load, match, pick or check, locate, commit, one at a time.
//  - A finished result sits in the output register; the next request may be
//    taken while it waits. If the receiver still stalls when the following
//    result is ready, the commit step holds and the table does not change.
//  - Reset clears all reference counts, dirty marks, the table start and the
//    result valid; no clearing pass is needed.
module refcounted_inode_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ric_pkg::BLK_W-1:0]     cfg_inode_table_start_i,
  // requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [ric_pkg::DEV_W-1:0]     device_i,
  input  logic [ric_pkg::INO_W-1:0]     inode_number_i,
  input  logic [ric_pkg::IDX_W-1:0]     slot_i,
  input  logic                          modified_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ric_pkg::STAT_W-1:0]    status_o,
  output logic [ric_pkg::IDX_W-1:0]     slot_index_o,
  output logic [ric_pkg::BLK_W-1:0]     disk_block_o,
  output logic [ric_pkg::OFF_W-1:0]     block_offset_o,
  output logic [ric_pkg::CNT_W-1:0]     references_o
);

  ric_pkg::ctrl_t    ctrl;
  ric_pkg::dp_stat_t stat;

  // Requests are taken only on the load step
  assign in_stall_o  = (ctrl.op != ric_pkg::OP_LOAD);
  assign cfg_ready_o = 1'b1;

  ric_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ric_datapath u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .ctrl_i                  (ctrl),
    .stat_o                  (stat),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_inode_table_start_i (cfg_inode_table_start_i),
    .in_valid_i              (in_valid_i),
    .command_i               (command_i),
    .device_i                (device_i),
    .inode_number_i          (inode_number_i),
    .slot_i                  (slot_i),
    .modified_i              (modified_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .status_o                (status_o),
    .slot_index_o            (slot_index_o),
    .disk_block_o            (disk_block_o),
    .block_offset_o          (block_offset_o),
    .references_o            (references_o)
  );

endmodule

### hdl/ric_sequencer.sv
// ric_sequencer: step counter and control store of the inode cache.
// Depends on ric_pkg.
module ric_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ric_pkg::dp_stat_t stat_i,
  output ric_pkg::ctrl_t    ctrl_o
);

  logic [ric_pkg::STEP_W-1:0] step_q, step_d;
  ric_pkg::ctrl_t             cw;
  logic                       jump;

  // Fetch the control word for the current step
  assign cw     = ric_pkg::rom_word(step_q);
  assign ctrl_o = cw;

  // Jump condition
  always_comb begin
    unique case (cw.cond)
      ric_pkg::CND_NEVER:    jump = 1'b0;
      ric_pkg::CND_ALWAYS:   jump = 1'b1;
      ric_pkg::CND_IN_ACC:   jump = in_valid_i;
      ric_pkg::CND_PUT:      jump = stat_i.is_put;
      ric_pkg::CND_OUT_FREE: jump = stat_i.out_free;
      default:               jump = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (jump) begin
      step_d = cw.target;
    end else if (cw.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ric_pkg::STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

  // Only the six programmed steps are ever reached
  a_step_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= ric_pkg::STEP_COMMIT)
    else $error("sequencer left the program");

  // An accepted word always starts at the match step
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ric_pkg::STEP_LOAD && in_valid_i) |=> step_q == ric_pkg::STEP_MATCH)
    else $error("accepted word did not start the program");

endmodule

### hdl/ric_datapath.sv
// ric_datapath: slot table, key compare, priority pick, block math and result register.
// Driven by control words from ric_sequencer; depends on ric_pkg.
module ric_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ric_pkg::ctrl_t                ctrl_i,
  output ric_pkg::dp_stat_t             stat_o,
  // configuration
  input  logic                          cfg_valid_i,
  input  logic [ric_pkg::BLK_W-1:0]     cfg_inode_table_start_i,
  // input word
  input  logic                          in_valid_i,
  input  logic                          command_i,
  input  logic [ric_pkg::DEV_W-1:0]     device_i,
  input  logic [ric_pkg::INO_W-1:0]     inode_number_i,
  input  logic [ric_pkg::IDX_W-1:0]     slot_i,
  input  logic                          modified_i,
  // result word
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ric_pkg::STAT_W-1:0]    status_o,
  output logic [ric_pkg::IDX_W-1:0]     slot_index_o,
  output logic [ric_pkg::BLK_W-1:0]     disk_block_o,
  output logic [ric_pkg::OFF_W-1:0]     block_offset_o,
  output logic [ric_pkg::CNT_W-1:0]     references_o
);

  localparam int SLOTS  = ric_pkg::SLOTS;
  localparam int SLOT_W = ric_pkg::SLOT_W;
  localparam int CNT_W  = ric_pkg::CNT_W;

  // Slot table
  logic [CNT_W-1:0]          ref_count_q   [SLOTS];
  logic                      entry_dirty_q [SLOTS];
  logic [ric_pkg::DEV_W-1:0] entry_device_q[SLOTS];
  logic [ric_pkg::INO_W-1:0] entry_inode_q [SLOTS];

  // Working registers
  logic [ric_pkg::BLK_W-1:0] start_q;
  logic                      cmd_q;
  logic                      mod_q;
  logic [ric_pkg::DEV_W-1:0] dev_q;
  logic [ric_pkg::INO_W-1:0] ino_q;
  logic [ric_pkg::IDX_W-1:0] slot_q;
  logic [SLOTS-1:0]          hit_vec_q, free_vec_q;
  logic                      hit_q, full_q, range_bad_q;
  logic [SLOT_W-1:0]         ptr_q;
  logic [ric_pkg::BLK_W-1:0] blk_q;
  logic [ric_pkg::OFF_W-1:0] off_q;

  // Result register
  logic                       out_valid_q;
  logic [ric_pkg::STAT_W-1:0] status_q, status_d;
  logic [ric_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [ric_pkg::BLK_W-1:0]  oblk_q, oblk_d;
  logic [ric_pkg::OFF_W-1:0]  ooff_q, ooff_d;
  logic [CNT_W-1:0]           refs_q, refs_d;

  logic                      in_acc, out_free, commit;
  logic [SLOTS-1:0]          hit_vec, free_vec;
  logic [SLOT_W-1:0]         hit_idx, free_idx;
  logic [ric_pkg::INO_W-1:0] zino;
  logic [CNT_W-1:0]          cnt_rd, cnt_new;
  logic                      dirty_rd, put_bad, wr_count, wr_key, wr_dirty, dirty_new;

  assign in_acc   = in_valid_i && (ctrl_i.op == ric_pkg::OP_LOAD);
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (ctrl_i.op == ric_pkg::OP_COMMIT) && out_free;
  assign stat_o   = '{is_put: cmd_q, out_free: out_free};

  // Parallel key compare and free scan
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = (ref_count_q[i] == '0);
      hit_vec[i]  = !free_vec[i] && (entry_device_q[i] == dev_q)
                    && (entry_inode_q[i] == ino_q);
    end
  end

  // Lowest-index pick over the registered vectors
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec_q[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (free_vec_q[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Inode location: zero-based inode number, wraps for inode zero
  assign zino = ino_q - 1'b1;

  // Commit: update of the chosen slot and the result word
  assign cnt_rd   = ref_count_q[ptr_q];
  assign dirty_rd = entry_dirty_q[ptr_q];
  assign put_bad  = range_bad_q || (cnt_rd == '0);

  always_comb begin
    wr_count  = 1'b0;
    wr_key    = 1'b0;
    wr_dirty  = 1'b0;
    dirty_new = 1'b0;
    cnt_new   = cnt_rd;
    status_d  = ric_pkg::STAT_FULL;
    idx_d     = '0;
    oblk_d    = '0;
    ooff_d    = '0;
    refs_d    = '0;
    if (cmd_q == ric_pkg::CMD_GET) begin
      if (hit_q) begin
        // saturating bump
        cnt_new  = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
        wr_count = 1'b1;
        status_d = ric_pkg::STAT_HIT;
        idx_d    = ric_pkg::IDX_W'(ptr_q);
        oblk_d   = blk_q;
        ooff_d   = off_q;
        refs_d   = cnt_new;
      end else if (!full_q) begin
        cnt_new   = CNT_W'(1);
        wr_count  = 1'b1;
        wr_key    = 1'b1;
        wr_dirty  = 1'b1;
        dirty_new = 1'b0;
        status_d  = ric_pkg::STAT_ALLOC;
        idx_d     = ric_pkg::IDX_W'(ptr_q);
        oblk_d    = blk_q;
        ooff_d    = off_q;
        refs_d    = cnt_new;
      end
    end else begin
      idx_d = slot_q;
      if (put_bad) begin
        status_d = ric_pkg::STAT_BAD;
      end else begin
        cnt_new   = cnt_rd - 1'b1;
        wr_count  = 1'b1;
        wr_dirty  = 1'b1;
        dirty_new = dirty_rd || mod_q;
        refs_d    = cnt_new;
        if (cnt_new != '0) begin
          status_d = ric_pkg::STAT_HELD;
        end else if (dirty_new) begin
          status_d = ric_pkg::STAT_WRITEBACK;
          oblk_d   = blk_q;
          ooff_d   = off_q;
        end else begin
          status_d = ric_pkg::STAT_CLEAN;
        end
      end
    end
  end

  // Counts, dirty marks, table start and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        ref_count_q[i]   <= '0;
        entry_dirty_q[i] <= 1'b0;
      end
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        start_q <= cfg_inode_table_start_i;
      end
      if (commit && wr_count) begin
        ref_count_q[ptr_q] <= cnt_new;
      end
      if (commit && wr_dirty) begin
        entry_dirty_q[ptr_q] <= dirty_new;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Keys and working registers
  always_ff @(posedge clk_i) begin
    if (commit && wr_key) begin
      entry_device_q[ptr_q] <= dev_q;
      entry_inode_q[ptr_q]  <= ino_q;
    end
    unique case (ctrl_i.op)
      ric_pkg::OP_LOAD: begin
        if (in_acc) begin
          cmd_q  <= command_i;
          dev_q  <= device_i;
          ino_q  <= inode_number_i;
          slot_q <= slot_i;
          mod_q  <= modified_i;
        end
      end
      ric_pkg::OP_MATCH: begin
        hit_vec_q  <= hit_vec;
        free_vec_q <= free_vec;
      end
      ric_pkg::OP_PICK: begin
        hit_q  <= |hit_vec_q;
        full_q <= ~|free_vec_q;
        ptr_q  <= (|hit_vec_q) ? hit_idx : free_idx;
      end
      ric_pkg::OP_CHECK: begin
        ptr_q       <= SLOT_W'(slot_q);
        range_bad_q <= (32'(slot_q) >= 32'(SLOTS));
        ino_q       <= entry_inode_q[SLOT_W'(slot_q)];
      end
      ric_pkg::OP_LOCATE: begin
        blk_q <= zino / ric_pkg::INODES_PER_BLOCK + start_q;
        off_q <= ric_pkg::OFF_W'(zino % ric_pkg::INODES_PER_BLOCK);
      end
      ric_pkg::OP_COMMIT: begin
        if (commit) begin
          status_q <= status_d;
          idx_q    <= idx_d;
          oblk_q   <= oblk_d;
          ooff_q   <= ooff_d;
          refs_q   <= refs_d;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = idx_q;
  assign disk_block_o   = oblk_q;
  assign block_offset_o = ooff_q;
  assign references_o   = refs_q;

  // A new result appears only after a commit step
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result word without commit");

  // A hit found at the pick step still points at a referenced slot at commit
  a_hit_referenced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && cmd_q == ric_pkg::CMD_GET && hit_q) |-> cnt_rd != '0)
    else $error("hit on a free slot");

endmodule

### sim/ric_checker.sv
// ric_checker: watches the config, request and result channels of the inode cache,
// keeps its own copy of the slot table and checks every result word field by field.
// Depends on ric_pkg.
module ric_checker
  import ric_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // config channel
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [BLK_W-1:0]  cfg_inode_table_start_i,
  // request channel
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              command_i,
  input  logic [DEV_W-1:0]  device_i,
  input  logic [INO_W-1:0]  inode_number_i,
  input  logic [IDX_W-1:0]  slot_i,
  input  logic              modified_i,
  // result channel
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [STAT_W-1:0] status_i,
  input  logic [IDX_W-1:0]  slot_index_i,
  input  logic [BLK_W-1:0]  disk_block_i,
  input  logic [OFF_W-1:0]  block_offset_i,
  input  logic [CNT_W-1:0]  references_i,
  // totals for the testbench top
  output int                mismatches_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  slot_index;
    logic [BLK_W-1:0]  disk_block;
    logic [OFF_W-1:0]  block_offset;
    logic [CNT_W-1:0]  references;
  } cache_result_t;

  // Shadow of the slot table
  logic [BLK_W-1:0] table_start;
  logic [CNT_W-1:0] live_refs [SLOTS];
  logic [DEV_W-1:0] owner_dev [SLOTS];
  logic [INO_W-1:0] owner_ino [SLOTS];
  logic             dirty     [SLOTS];

  // Result words predicted but not yet seen, oldest first
  cache_result_t awaited_results [$];

  // Print a capped number of lines, count every mismatch
  task automatic report_mismatch(input string what);
    if (mismatches_o < 100) $display("[%0t] mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  task automatic compare_field(input string field, input longint unsigned got,
                               input longint unsigned want, input int word);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                word, field, got, want));
  endtask

  // Disk block and offset of an inode; inode zero wraps
  function automatic void inode_location(input logic [INO_W-1:0] ino,
                                         output logic [BLK_W-1:0] blk,
                                         output logic [OFF_W-1:0] off);
    logic [INO_W-1:0] z;
    z   = ino - 1'b1;
    blk = BLK_W'(z / BLK_W'(INODES_PER_BLOCK)) + table_start;
    off = OFF_W'(z % INODES_PER_BLOCK);
  endfunction

  // Apply one request to the shadow table and return its result word
  function automatic cache_result_t cache_response(input logic cmd,
                                                   input logic [DEV_W-1:0] dev,
                                                   input logic [INO_W-1:0] ino,
                                                   input logic [IDX_W-1:0] s,
                                                   input logic mod);
    cache_result_t r;
    int hit_at;
    int free_at;
    r       = '0;
    hit_at  = -1;
    free_at = -1;
    if (cmd == CMD_GET) begin
      // descending scan so the lowest match and the lowest free slot win
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (live_refs[i] != 0 && owner_dev[i] == dev && owner_ino[i] == ino) hit_at = i;
        if (live_refs[i] == 0) free_at = i;
      end
      if (hit_at >= 0) begin
        if (live_refs[hit_at] != '1) live_refs[hit_at]++;
        r.status     = STAT_HIT;
        r.slot_index = IDX_W'(hit_at);
        r.references = live_refs[hit_at];
        inode_location(ino, r.disk_block, r.block_offset);
      end else if (free_at >= 0) begin
        live_refs[free_at] = 1;
        owner_dev[free_at] = dev;
        owner_ino[free_at] = ino;
        dirty[free_at]     = 1'b0;
        r.status     = STAT_ALLOC;
        r.slot_index = IDX_W'(free_at);
        r.references = 1;
        inode_location(ino, r.disk_block, r.block_offset);
      end else begin
        r.status = STAT_FULL;
      end
    end else begin
      r.slot_index = s;
      if (s >= SLOTS || live_refs[s] == 0) begin
        r.status = STAT_BAD;
      end else begin
        if (mod) dirty[s] = 1'b1;
        live_refs[s]--;
        r.references = live_refs[s];
        if (live_refs[s] != 0) begin
          r.status = STAT_HELD;
        end else if (dirty[s]) begin
          r.status = STAT_WRITEBACK;
          inode_location(owner_ino[s], r.disk_block, r.block_offset);
        end else begin
          r.status = STAT_CLEAN;
        end
      end
    end
    return r;
  endfunction

  // Result side first: a word leaving now always belongs to an older request
  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t want;
    if (!rst_ni) begin
      table_start = '0;
      for (int i = 0; i < SLOTS; i++) begin
        live_refs[i] = '0;
        owner_dev[i] = '0;
        owner_ino[i] = '0;
        dirty[i]     = 1'b0;
      end
      awaited_results.delete();
      mismatches_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word with no request waiting, status %0d",
                                    status_i));
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", status_i, want.status, checked_o);
          compare_field("slot_index", slot_index_i, want.slot_index, checked_o);
          compare_field("disk_block", disk_block_i, want.disk_block, checked_o);
          compare_field("block_offset", block_offset_i, want.block_offset, checked_o);
          compare_field("references", references_i, want.references, checked_o);
        end
        checked_o++;
      end
      if (cfg_valid_i && cfg_ready_i) table_start = cfg_inode_table_start_i;
      if (in_valid_i && !in_stall_i)
        awaited_results.push_back(cache_response(command_i, device_i, inode_number_i,
                                                 slot_i, modified_i));
    end
    pending_o = awaited_results.size();
  end

endmodule

### sim/refcounted_inode_cache_tb.sv
// refcounted_inode_cache_tb: drives requests, config writes and result stalls into the
// inode cache and gives the verdict; checking lives in ric_checker.
// Depends on ric_pkg, ric_checker and the cache RTL.
module refcounted_inode_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ric_pkg::*;

  localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on any channel
  localparam int DRAIN_CYCLES  = 10;    // cycles of extra wait once no result is pending
  localparam int SAME_KEY_GETS = 6;     // repeated gets on one key

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [BLK_W-1:0]  cfg_inode_table_start_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              command_i = CMD_GET;
  logic [DEV_W-1:0]  device_i = '0;
  logic [INO_W-1:0]  inode_number_i = '0;
  logic [IDX_W-1:0]  slot_i = '0;
  logic              modified_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [IDX_W-1:0]  slot_index_o;
  logic [BLK_W-1:0]  disk_block_o;
  logic [OFF_W-1:0]  block_offset_o;
  logic [CNT_W-1:0]  references_o;

  int mismatches;
  int pending_words;
  int results_checked;

  int gap_pct = 0;       // chance per cycle that the sender holds back
  int stall_pct = 0;     // chance per cycle that the receiver stalls
  int requests_sent = 0;
  int quiet_cycles = 0;
  bit filling = 1'b1;    // random mix leans toward gets while set

  // Rough occupancy of the table, only used to steer stimulus
  int               occ_refs [SLOTS];
  logic [DEV_W-1:0] occ_dev  [SLOTS];
  logic [INO_W-1:0] occ_ino  [SLOTS];

  refcounted_inode_cache dut (.*);

  ric_checker u_checker (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_i             (cfg_ready_o),
    .cfg_inode_table_start_i (cfg_inode_table_start_i),
    .in_valid_i              (in_valid_i),
    .in_stall_i              (in_stall_o),
    .command_i               (command_i),
    .device_i                (device_i),
    .inode_number_i          (inode_number_i),
    .slot_i                  (slot_i),
    .modified_i              (modified_i),
    .out_valid_i             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .status_i                (status_o),
    .slot_index_i            (slot_index_o),
    .disk_block_i            (disk_block_o),
    .block_offset_i          (block_offset_o),
    .references_i            (references_o),
    .mismatches_o            (mismatches),
    .pending_o               (pending_words),
    .checked_o               (results_checked)
  );

  always #10 clk_i = ~clk_i;

  // Receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no channel moved for %0d cycles", QUIET_LIMIT);
      $display("refcounted_inode_cache_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int held_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (occ_refs[i] != 0) n++;
    return n;
  endfunction

  // Pick one held slot uniformly; caller makes sure one exists
  function automatic int random_held_slot();
    int n;
    n = $urandom_range(held_slots() - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (occ_refs[i] != 0) begin
        if (n == 0) return i;
        n--;
      end
    end
    return 0;
  endfunction

  // Follow the table: a get hits a held key or takes the lowest free slot
  function automatic void track_request(input logic cmd, input logic [DEV_W-1:0] dev,
                                        input logic [INO_W-1:0] ino,
                                        input logic [IDX_W-1:0] s);
    int at;
    at = -1;
    if (cmd == CMD_GET) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (occ_refs[i] == 0) at = i;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (occ_refs[i] != 0 && occ_dev[i] == dev && occ_ino[i] == ino) at = i;
      if (at >= 0) begin
        if (occ_refs[at] == 0) begin
          occ_dev[at] = dev;
          occ_ino[at] = ino;
        end
        occ_refs[at]++;
      end
    end else if (occ_refs[s] != 0) begin
      occ_refs[s]--;
    end
  endfunction

  // One request word; returns at the edge that took it
  task automatic send_request(input logic cmd, input logic [DEV_W-1:0] dev,
                              input logic [INO_W-1:0] ino, input logic [IDX_W-1:0] s,
                              input logic mod);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    device_i       <= dev;
    inode_number_i <= ino;
    slot_i         <= s;
    modified_i     <= mod;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_request(cmd, dev, ino, s);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only called while the cache is idle
  task automatic write_table_start(input logic [BLK_W-1:0] value);
    cfg_valid_i             <= 1'b1;
    cfg_inode_table_start_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random mix: mostly gets on held or fresh keys and releases of held slots,
  // a little noise on arbitrary slots
  task automatic random_request();
    int held;
    int roll;
    int pick;
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    logic [IDX_W-1:0] s;
    held = held_slots();
    dev  = DEV_W'($urandom_range(0, 16'hFFFF));
    ino  = $urandom();
    s    = IDX_W'($urandom_range(0, SLOTS - 1));
    if (held == SLOTS && filling && $urandom_range(7) == 0) filling = 1'b0;
    if (held == 0) filling = 1'b1;
    if ($urandom_range(39) == 0) filling = !filling;
    roll = $urandom_range(99);
    if (roll < 3) begin
      send_request(CMD_PUT, dev, ino, s, 1'($urandom_range(1)));
    end else if (held > 0 && roll < (filling ? 38 : 10)) begin
      // get on a key already held
      pick = random_held_slot();
      send_request(CMD_GET, occ_dev[pick], occ_ino[pick], s, 1'($urandom_range(1)));
    end else if (roll < (filling ? 78 : 15)) begin
      // get on a fresh key
      if ($urandom_range(3) == 0) dev = DEV_W'($urandom_range(0, 3));
      case ($urandom_range(7))
        0: ino = '0;
        1: ino = '1;
        2, 3: ino = INO_W'($urandom_range(1, 16));
        4: if (held > 0) ino = occ_ino[random_held_slot()];
        default: ;
      endcase
      send_request(CMD_GET, dev, ino, s, 1'($urandom_range(1)));
    end else if (held > 0) begin
      send_request(CMD_PUT, dev, ino, IDX_W'(random_held_slot()), 1'($urandom_range(1)));
    end else begin
      send_request(CMD_PUT, dev, ino, s, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [DEV_W-1:0] sat_dev;
    logic [INO_W-1:0] sat_ino;
    for (int i = 0; i < SLOTS; i++) begin
      occ_refs[i] = 0;
      occ_dev[i]  = '0;
      occ_ino[i]  = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender rarely idles, receiver stalls half the time
    gap_pct   = 10;
    stall_pct = 50;
    write_table_start('0);
    send_request(CMD_GET, 16'h0000, 32'd1, '0, 1'b0);          // allocate slot 0
    send_request(CMD_GET, 16'h0000, 32'd1, '1, 1'b1);          // hit, count two
    send_request(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, '0, 1'b0);  // largest key
    send_request(CMD_GET, 16'h0000, 32'd0, '0, 1'b0);          // inode zero wraps
    send_request(CMD_PUT, 16'hFFFF, '1, 6'd0, 1'b0);           // still held
    send_request(CMD_PUT, 16'h0000, '0, 6'd0, 1'b1);           // freed, write back
    send_request(CMD_PUT, 16'h0000, '0, 6'd0, 1'b1);           // release of free slot
    send_request(CMD_PUT, 16'h0000, '0, 6'd63, 1'b0);          // never claimed
    send_request(CMD_PUT, 16'h0000, '0, 6'd1, 1'b0);           // freed clean
    send_request(CMD_GET, 16'h0000, 32'd1, '0, 1'b0);          // reclaim, dirty cleared
    send_request(CMD_PUT, 16'h0000, '0, 6'd0, 1'b0);           // so freed clean
    send_request(CMD_GET, 16'h0001, 32'd1, '0, 1'b0);          // same inode, other device
    send_request(CMD_GET, 16'h0000, 32'd1, '0, 1'b0);
    send_request(CMD_GET, 16'hFFFF, 32'd8, '0, 1'b0);          // last offset of block 0
    send_request(CMD_GET, 16'hFFFF, 32'd9, '0, 1'b0);          // first offset of block 1
    repeat (150) random_request();
    wait_drained();

    // Phase two: sender idles half the time, receiver rarely stalls
    gap_pct   = 50;
    stall_pct = 10;
    write_table_start('1);
    send_request(CMD_GET, 16'h8000, 32'hFFFF_FFFF, '0, 1'b0);  // block wraps past the top
    repeat (150) random_request();
    wait_drained();

    // Phase three: no idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    write_table_start($urandom());
    repeat (140) random_request();

    // Empty the table, then stack several references on one key
    for (int i = 0; i < SLOTS; i++)
      while (occ_refs[i] != 0) send_request(CMD_PUT, '0, '0, IDX_W'(i), 1'($urandom_range(1)));
    sat_dev = DEV_W'($urandom_range(0, 16'hFFFF));
    sat_ino = $urandom();
    repeat (SAME_KEY_GETS) send_request(CMD_GET, sat_dev, sat_ino, '0, 1'b0);
    send_request(CMD_PUT, '0, '0, 6'd0, 1'b1);
    repeat (SAME_KEY_GETS - 1) send_request(CMD_PUT, '0, '0, 6'd0, 1'b0);
    wait_drained();

    $display("run covered %0d requests under table starts of zero, all ones and a random value,",
             requests_sent);
    $display("with full-table, bad-release, write-back and repeated-key cases; %0d results compared",
             results_checked);
    if (mismatches == 0) begin
      $display("refcounted_inode_cache_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("refcounted_inode_cache_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ric_pkg.sv
hdl/ric_sequencer.sv
hdl/ric_datapath.sv
hdl/refcounted_inode_cache.sv
sim/ric_checker.sv
sim/refcounted_inode_cache_tb.sv
